[design/rgb_cross_gradient_edge_map_defines.svh]
// Assertion helpers used by the edge-map RTL.
`ifndef RGB_CROSS_GRADIENT_EDGE_MAP_DEFINES_SVH
`define RGB_CROSS_GRADIENT_EDGE_MAP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define RCGEM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcgem: assertion failed");

// Next-cycle implication, off while reset is asserted.
`define RCGEM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcgem: assertion failed");

`endif

[design/rcgem_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rcgem_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  gray;
    logic [15:0] out_row;
    logic [11:0] out_col;
    logic        frame_end;
  } result_t;

  // Request to the edge unit: center pixel plus up to four neighbours.
  typedef struct packed {
    logic             start;
    pixel_t           center;
    pixel_t [3:0]     nb;
    logic   [3:0]     nb_valid;
  } edge_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] gray;
  } edge_rsp_t;

endpackage

`default_nettype wire

[design/rgb_cross_gradient_edge_map.sv]
// Edge map of an RGB raster, one pixel transaction at a time.
// Each pixel releases 0..3 results; no new pixel is taken until the previous one's results are all out,
// which takes four serial line-buffer reads and, per result, the edge unit's serial /255 curve loop.
// Reset (rst_ni low, async): counters to row 0 col 0, width 640, height 480, output empty;
// line buffers are not cleared, no sweep: data not yet written in a frame may be read, but it is masked and never used.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_cross_gradient_edge_map_defines.svh"

module rgb_cross_gradient_edge_map #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire rcgem_pkg::pixel_t   in_data_i,

  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rcgem_pkg::result_t       out_data_o,

  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // column counter, line-buffer address, effective-width widths
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = $clog2(2 * MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > 13) ? $clog2(MAX_WIDTH + 1) : 13;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // sequencer
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;  // four line-buffer reads, write of this pixel
  localparam logic [2:0] S_NEXT = 3'd2;  // pick next result kind, start edge unit
  localparam logic [2:0] S_BUSY = 3'd3;  // edge unit running
  localparam logic [2:0] S_EMIT = 3'd4;  // wait for room in output register

  // result kinds, in output order
  localparam logic [1:0] KIND_UP   = 2'd0;  // pixel above the incoming one
  localparam logic [1:0] KIND_LEFT = 2'd1;  // last row: pixel to the left
  localparam logic [1:0] KIND_SELF = 2'd2;  // last row, last column: the pixel itself
  localparam logic [1:0] KIND_DONE = 2'd3;

  logic [2:0]  state_q, state_d;
  logic [12:0] width_q;
  logic [15:0] height_q;
  logic [15:0] row_q;
  logic [CW-1:0] col_q;

  // per-transaction context
  rcgem_pkg::pixel_t cur_q;
  logic [15:0]   r_q;
  logic [CW-1:0] c_q;
  logic          up_ok_q, up2_ok_q, left_ok_q, left2_ok_q, right_ok_q;
  logic          last_row_q, last_col_q;
  rcgem_pkg::pixel_t slot_q [4];  // up2, prev left, prev center, prev right
  logic [2:0]    rd_idx_q;
  logic [1:0]    kind_q;
  rcgem_pkg::pixel_t left0_q, left1_q;

  logic               out_valid_q;
  rcgem_pkg::result_t out_data_q;

  rcgem_pkg::edge_req_t edge_req;
  rcgem_pkg::edge_rsp_t edge_rsp;

  // ---------------------------------------------------------------------------
  // Effective frame size: width 0 acts as 1 and is capped at MAX_WIDTH,
  // height 0 acts as 1.
  // ---------------------------------------------------------------------------
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;

  always_comb begin
    if (width_q == 13'd0) begin
      w_eff = WW'(1);
    end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
  end

  // ---------------------------------------------------------------------------
  // Configuration port. Any write to a known register restarts the frame.
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input acceptance and raster counters
  // ---------------------------------------------------------------------------
  logic          in_acc;
  logic [WW-1:0] col_p1_ext;
  logic [16:0]   row_p1;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign col_p1_ext = WW'(col_q) + WW'(1);
  assign row_p1     = 17'(row_q) + 17'd1;

  // ---------------------------------------------------------------------------
  // Line buffer: row r lives in half (r & 1). Reads go out one a cycle;
  // the incoming pixel overwrites its slot once the up2 read has been issued.
  // ---------------------------------------------------------------------------
  logic [AW-1:0] base_cur, base_prev;
  logic [CW-1:0] col_m1, col_p1;
  logic [AW-1:0] ram_raddr, ram_waddr;
  logic          ram_we;
  rcgem_pkg::pixel_t ram_rdata;

  always_comb begin
    base_cur  = r_q[0] ? AW'(MAX_WIDTH) : AW'(0);
    base_prev = r_q[0] ? AW'(0) : AW'(MAX_WIDTH);
    // out-of-row neighbours fall back to the center column; their data is masked
    col_m1 = left_ok_q  ? c_q - CW'(1) : c_q;
    col_p1 = right_ok_q ? c_q + CW'(1) : c_q;
    case (rd_idx_q[1:0])
      2'd0:    ram_raddr = base_cur  + AW'(c_q);
      2'd1:    ram_raddr = base_prev + AW'(col_m1);
      2'd2:    ram_raddr = base_prev + AW'(c_q);
      2'd3:    ram_raddr = base_prev + AW'(col_p1);
      default: ram_raddr = base_cur  + AW'(c_q);
    endcase
    ram_waddr = base_cur + AW'(c_q);
    ram_we    = (state_q == S_READ) && (rd_idx_q == 3'd1);
  end

  rcgem_ram #(
    .WIDTH ($bits(rcgem_pkg::pixel_t)),
    .DEPTH (2 * MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cur_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result selection: which kinds this pixel releases, and their neighbourhoods
  // ---------------------------------------------------------------------------
  logic need;

  always_comb begin
    case (kind_q)
      KIND_UP:   need = up_ok_q;
      KIND_LEFT: need = last_row_q && left_ok_q;
      KIND_SELF: need = last_row_q && last_col_q;
      default:   need = 1'b0;
    endcase
  end

  always_comb begin
    edge_req          = '0;
    edge_req.start    = (state_q == S_NEXT) && need;
    case (kind_q)
      KIND_UP: begin
        edge_req.center   = slot_q[2];
        edge_req.nb[0]    = slot_q[0];
        edge_req.nb[1]    = slot_q[1];
        edge_req.nb[2]    = cur_q;
        edge_req.nb[3]    = slot_q[3];
        edge_req.nb_valid = {right_ok_q, 1'b1, left_ok_q, up2_ok_q};
      end
      KIND_LEFT: begin
        edge_req.center   = left0_q;
        edge_req.nb[0]    = slot_q[1];
        edge_req.nb[1]    = left1_q;
        edge_req.nb[2]    = cur_q;
        edge_req.nb_valid = {1'b0, 1'b1, left2_ok_q, up_ok_q};
      end
      KIND_SELF: begin
        edge_req.center   = cur_q;
        edge_req.nb[0]    = slot_q[2];
        edge_req.nb[1]    = left0_q;
        edge_req.nb_valid = {1'b0, 1'b0, left_ok_q, up_ok_q};
      end
      default: begin
        edge_req.nb_valid = 4'b0000;
      end
    endcase
  end

  rcgem_edge u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (edge_req),
    .rsp_o  (edge_rsp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_load;
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_READ;
      S_READ: if (rd_idx_q == 3'd4) state_d = S_NEXT;
      S_NEXT: begin
        if (kind_q == KIND_DONE) begin
          state_d = S_IDLE;
        end else if (need) begin
          state_d = S_BUSY;
        end
      end
      S_BUSY: if (edge_rsp.done) state_d = S_EMIT;
      S_EMIT: if (out_load) state_d = S_NEXT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= 13'd640;
      height_q    <= 16'd480;
      row_q       <= 16'd0;
      col_q       <= '0;
      rd_idx_q    <= 3'd0;
      kind_q      <= KIND_UP;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // config must be written only while idle (user's duty, unenforced); any write restarts the frame
      if (cfg_wr) begin
        case (paddr[2])
          REG_WIDTH:  width_q  <= pwdata[12:0];
          REG_HEIGHT: height_q <= pwdata[15:0];
          default:    width_q  <= width_q;
        endcase
        row_q <= 16'd0;
        col_q <= '0;
      end else if (in_acc) begin
        if (col_p1_ext >= w_eff) begin
          col_q <= '0;
          row_q <= (row_p1 >= 17'(h_eff)) ? 16'd0 : row_p1[15:0];
        end else begin
          col_q <= col_q + CW'(1);
        end
      end

      if (in_acc) begin
        rd_idx_q <= 3'd0;
      end else if (state_q == S_READ) begin
        rd_idx_q <= rd_idx_q + 3'd1;
      end

      if (state_q == S_READ) begin
        kind_q <= KIND_UP;
      end else if ((state_q == S_NEXT && !need && kind_q != KIND_DONE) || out_load) begin
        kind_q <= kind_q + 2'd1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q      <= in_data_i;
      r_q        <= row_q;
      c_q        <= col_q;
      up_ok_q    <= (row_q != 16'd0);
      up2_ok_q   <= (row_q > 16'd1);
      left_ok_q  <= (col_q != '0);
      left2_ok_q <= (WW'(col_q) > WW'(1));
      right_ok_q <= (col_p1_ext < w_eff);
      last_col_q <= (col_p1_ext == w_eff);
      last_row_q <= (row_p1 == 17'(h_eff));
    end
    // read data arrives in the cycle after its address
    if (state_q == S_READ && rd_idx_q != 3'd0) begin
      slot_q[2'(rd_idx_q - 3'd1)] <= ram_rdata;
    end
    // the two left pixels shift once all results of this pixel are out
    if (state_q == S_NEXT && kind_q == KIND_DONE) begin
      left1_q <= left0_q;
      left0_q <= cur_q;
    end
    if (out_load) begin
      out_data_q.gray <= edge_rsp.gray;
      case (kind_q)
        KIND_UP: begin
          out_data_q.out_row   <= r_q - 16'd1;
          out_data_q.out_col   <= 12'(c_q);
          out_data_q.frame_end <= 1'b0;
        end
        KIND_LEFT: begin
          out_data_q.out_row   <= r_q;
          out_data_q.out_col   <= 12'(c_q - CW'(1));
          out_data_q.frame_end <= 1'b0;
        end
        default: begin
          out_data_q.out_row   <= r_q;
          out_data_q.out_col   <= 12'(c_q);
          out_data_q.frame_end <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RCGEM_ASSERT_NXT(a_accept_reads, clk_i, rst_ni, in_acc, state_q == S_READ)
  `RCGEM_ASSERT_IMP(a_done_in_busy, clk_i, rst_ni, edge_rsp.done, state_q == S_BUSY)
  `RCGEM_ASSERT_IMP(a_row_in_frame, clk_i, rst_ni, 1'b1, row_q < h_eff)
  `RCGEM_ASSERT_IMP(a_col_in_frame, clk_i, rst_ni, 1'b1, WW'(col_q) < w_eff)

endmodule

`default_nettype wire

[design/rcgem_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module rcgem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[design/rcgem_edge.sv]
`timescale 1ns / 1ps
`default_nettype none

module rcgem_edge (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rcgem_pkg::edge_req_t req_i,
  output rcgem_pkg::edge_rsp_t      rsp_o
);

  localparam logic [2:0] E_IDLE  = 3'd0;
  localparam logic [2:0] E_SUM   = 3'd1;
  localparam logic [2:0] E_DIV3  = 3'd2;
  localparam logic [2:0] E_DIVN  = 3'd3;
  localparam logic [2:0] E_SQR   = 3'd4;
  localparam logic [2:0] E_CURVE = 3'd5;

  localparam logic [2:0]  CurveSteps  = 3'd6;
  // floor(x/3) == (x*2731) >> 13 for every x up to 3060
  localparam logic [11:0] Recip3Mul   = 12'd2731;

  function automatic logic [7:0] abs_diff(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [9:0] pix_diff(rcgem_pkg::pixel_t a, rcgem_pkg::pixel_t b);
    return 10'(abs_diff(a.red, b.red)) + 10'(abs_diff(a.green, b.green))
         + 10'(abs_diff(a.blue, b.blue));
  endfunction

  // exact floor(x/255) for every x up to 255*255
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x >> 8) + 17'd1;
    return s[15:8];
  endfunction

  logic [2:0]  state_q, state_d;
  logic [9:0]  diff_q [4];
  logic [2:0]  cnt_q;
  logic [11:0] sum_q;
  logic [9:0]  s3_q;
  logic [7:0]  p_q;
  logic [7:0]  q_q;
  logic [15:0] prod_q;
  logic [2:0]  iter_q;
  logic [7:0]  gray_q;
  logic        done_q;

  logic [23:0] m3;
  logic [21:0] mn;
  logic [7:0]  p_d;
  logic [7:0]  q_d;

  always_comb begin
    m3 = 24'(sum_q) * 24'(Recip3Mul);
    mn = 22'(s3_q) * 22'(Recip3Mul);
    case (cnt_q)
      3'd1:    p_d = s3_q[7:0];
      3'd2:    p_d = s3_q[8:1];
      3'd3:    p_d = mn[20:13];
      3'd4:    p_d = s3_q[9:2];
      default: p_d = 8'd0;
    endcase
    q_d = 8'd255 - p_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      E_IDLE:  if (req_i.start) state_d = E_SUM;
      E_SUM:   state_d = E_DIV3;
      E_DIV3:  state_d = E_DIVN;
      E_DIVN:  state_d = E_SQR;
      E_SQR:   state_d = E_CURVE;
      E_CURVE: if (iter_q == CurveSteps) state_d = E_IDLE;
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == E_CURVE) && (iter_q == CurveSteps);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == E_IDLE && req_i.start) begin
      for (int k = 0; k < 4; k++) begin
        diff_q[k] <= req_i.nb_valid[k] ? pix_diff(req_i.center, req_i.nb[k]) : 10'd0;
      end
      cnt_q <= 3'($countones(req_i.nb_valid));
    end
    if (state_q == E_SUM) begin
      sum_q <= 12'(diff_q[0]) + 12'(diff_q[1]) + 12'(diff_q[2]) + 12'(diff_q[3]);
    end
    if (state_q == E_DIV3) begin
      s3_q <= m3[22:13];
    end
    if (state_q == E_DIVN) begin
      p_q <= p_d;
    end
    if (state_q == E_SQR) begin
      q_q    <= q_d;
      prod_q <= 16'(q_d) * 16'(q_d);
      iter_q <= 3'd1;
    end
    if (state_q == E_CURVE) begin
      if (iter_q == CurveSteps) begin
        gray_q <= div255(prod_q);
      end else begin
        prod_q <= 16'(div255(prod_q)) * 16'(q_q);
        iter_q <= iter_q + 3'd1;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.gray = gray_q;

endmodule

`default_nettype wire
